// ===== hdl/obstacle_proximity_cost_top_macros.svh =====
// Assertion macros shared by the obstacle proximity cost RTL.
`ifndef OBSTACLE_PROXIMITY_COST_TOP_MACROS_SVH
`define OBSTACLE_PROXIMITY_COST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OPC_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define OPC_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/opc_pkg.sv =====
// Types, constants and the danger table for the obstacle proximity cost block.
`timescale 1ns / 1ps
package opc_pkg;

  localparam int MAX_WALLS  = 64;
  localparam int MAX_ROBOTS = 16;

  localparam int WALL_AW  = $clog2(MAX_WALLS);
  localparam int WALL_CW  = $clog2(MAX_WALLS + 1);
  localparam int ROBOT_AW = $clog2(MAX_ROBOTS);
  localparam int ROBOT_CW = $clog2(MAX_ROBOTS + 1);
  localparam int SCAN_CW  = (WALL_CW > ROBOT_CW) ? WALL_CW : ROBOT_CW;

  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int COORD_W  = 16;
  localparam int POINT_W  = 2 * COORD_W;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int DANGER_W = 14;
  localparam int TOTAL_W  = 15;
  localparam int THR_W    = 15;
  localparam int NEAR_N   = 40;
  localparam int NEAR_IW  = $clog2(NEAR_N);
  localparam int OUT_W    = 48;

  localparam logic [DANGER_W-1:0] DIST_START = 14'd10000;
  localparam logic [DANGER_W-1:0] DIST_NEAR  = 14'd40;
  localparam logic [THR_W-1:0]    THR_RESET  = 15'd400;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_WALL   = 3'd0,
    CMD_DEL_WALL   = 3'd1,
    CMD_CLR_WALLS  = 3'd2,
    CMD_ADD_ROBOT  = 3'd3,
    CMD_CLR_ROBOTS = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sqd;
  } dist_t;

  // entry 0 is the direct hit, the rest are 1000 / d
  localparam logic [DANGER_W-1:0] DANGER_TBL [0:NEAR_N-1] = '{
    14'd10000, 14'd1000, 14'd500, 14'd333, 14'd250, 14'd200, 14'd166, 14'd142,
    14'd125,   14'd111,  14'd100, 14'd90,  14'd83,  14'd76,  14'd71,  14'd66,
    14'd62,    14'd58,   14'd55,  14'd52,  14'd50,  14'd47,  14'd45,  14'd43,
    14'd41,    14'd40,   14'd38,  14'd37,  14'd35,  14'd34,  14'd33,  14'd32,
    14'd31,    14'd30,   14'd29,  14'd28,  14'd27,  14'd27,  14'd26,  14'd25
  };

  function automatic logic [DANGER_W-1:0] danger_of(input logic [DANGER_W-1:0] dmin);
    logic [DANGER_W-1:0] res;
    res = '0;
    if (dmin < DIST_NEAR) begin
      res = DANGER_TBL[dmin[NEAR_IW-1:0]];
    end
    return res;
  endfunction

endpackage

// ===== hdl/opc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module opc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/opc_dist.sv =====
// Squared distance unit: registered squares, summed at the output.
`timescale 1ns / 1ps
module opc_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         issue,
  input  logic [opc_pkg::POINT_W-1:0]  pt,
  input  logic [opc_pkg::POINT_W-1:0]  query,
  output opc_pkg::dist_t               res
);
  import opc_pkg::*;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      mx, my;
  logic [SQ_W-1:0]         sqx_r, sqy_r;
  logic                    valid_r;

  assign dx = $signed({pt[COORD_W-1], pt[COORD_W-1:0]})
            - $signed({query[COORD_W-1], query[COORD_W-1:0]});
  assign dy = $signed({pt[POINT_W-1], pt[POINT_W-1:COORD_W]})
            - $signed({query[POINT_W-1], query[POINT_W-1:COORD_W]});
  assign mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= issue;
    end
    sqx_r <= mx * mx;
    sqy_r <= my * my;
  end

  assign res.valid = valid_r;
  assign res.sqd   = {1'b0, sqx_r} + {1'b0, sqy_r};

endmodule

// ===== hdl/obstacle_proximity_cost_top.sv =====
`timescale 1ns / 1ps
// Obstacle proximity cost: wall and robot point tables with a proximity query.
// Query: both tables are scanned from the start, one entry of both tables read per cycle,
// then drain, finish and result; the next transfer is accepted once the result is presented.
// Remove: search for the first match, then shift the later entries down; then the result.
// Add, clear, unknown: the result goes through ST_DONE into the output register.
// Reset: synchronous; counts cleared, threshold 400, tables left unwritten.
`include "obstacle_proximity_cost_top_macros.svh"
module obstacle_proximity_cost_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [opc_pkg::POINT_W-1:0] in_tdata,   // pos_x, pos_y
  input  logic [opc_pkg::CMD_W-1:0]   in_tuser,   // command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [opc_pkg::OUT_W-1:0]   out_tdata,  // wall_danger, robot_danger, total_danger, blocked
  output logic [opc_pkg::STAT_W-1:0]  out_tuser,  // status
  input  logic                        cfg_wr_en,
  input  logic [opc_pkg::THR_W-1:0]   cfg_wr_data
);
  import opc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_QSCAN, ST_QDRAIN, ST_QFIN, ST_RSRCH, ST_SHIFT, ST_DONE
  } state_t;

  state_t               state_r;
  logic [WALL_CW-1:0]   wc_r;
  logic [ROBOT_CW-1:0]  rc_r;
  logic [THR_W-1:0]     thr_r;
  logic [POINT_W-1:0]   pt_r;
  logic [SCAN_CW-1:0]   idx_r;
  logic [WALL_AW-1:0]   a0_r;
  logic                 v0w_r, v0r_r;
  logic [DANGER_W-1:0]  dminw_r, dminr_r;

  logic [DANGER_W-1:0]  res_wd_r, res_rd_r;
  logic [TOTAL_W-1:0]   res_tot_r;
  logic                 res_blk_r;
  status_t              res_st_r;

  logic                 out_valid_r;
  logic [DANGER_W-1:0]  out_wd_r, out_rd_r;
  logic [TOTAL_W-1:0]   out_tot_r;
  logic                 out_blk_r;
  status_t              out_st_r;

  cmd_t                 cmd_in;
  logic                 in_fire, w_more, r_more, wc_full, rc_full, match_hit, q_active;
  logic                 issue_w, issue_r;
  logic                 wall_we, robot_we;
  logic [WALL_AW-1:0]   wall_waddr;
  logic [ROBOT_AW-1:0]  robot_waddr;
  logic [POINT_W-1:0]   wall_wdata, robot_wdata, wall_rdata, robot_rdata;
  dist_t                dw, dr;
  logic [DANGER_W-1:0]  wd_v, rd_v;

  assign cmd_in    = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign w_more    = idx_r < SCAN_CW'(wc_r);
  assign r_more    = idx_r < SCAN_CW'(rc_r);
  assign wc_full   = (wc_r == WALL_CW'(MAX_WALLS));
  assign rc_full   = (rc_r == ROBOT_CW'(MAX_ROBOTS));
  assign match_hit = (state_r == ST_RSRCH) && v0w_r && (wall_rdata == pt_r);
  assign q_active  = (state_r == ST_QSCAN) || (state_r == ST_QDRAIN);

  always_comb begin
    issue_w     = 1'b0;
    issue_r     = 1'b0;
    wall_we     = 1'b0;
    wall_waddr  = wc_r[WALL_AW-1:0];
    wall_wdata  = in_tdata;
    robot_we    = 1'b0;
    robot_waddr = rc_r[ROBOT_AW-1:0];
    robot_wdata = in_tdata;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && cmd_in == CMD_ADD_WALL && !wc_full) begin
          wall_we = 1'b1;
        end
        if (in_fire && cmd_in == CMD_ADD_ROBOT && !rc_full) begin
          robot_we = 1'b1;
        end
      end
      ST_QSCAN: begin
        issue_w = w_more;
        issue_r = r_more;
      end
      ST_RSRCH: begin
        issue_w = w_more;
      end
      ST_SHIFT: begin
        issue_w = w_more;
        if (v0w_r) begin
          wall_we    = 1'b1;
          wall_waddr = WALL_AW'(a0_r - 1'b1);
          wall_wdata = wall_rdata;
        end
      end
      default: ;
    endcase
  end

  opc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_WALLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (idx_r[WALL_AW-1:0]),
    .rdata (wall_rdata)
  );

  opc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_ROBOTS)) u_robot_ram (
    .clk   (clk),
    .we    (robot_we),
    .waddr (robot_waddr),
    .wdata (robot_wdata),
    .raddr (idx_r[ROBOT_AW-1:0]),
    .rdata (robot_rdata)
  );

  opc_dist u_wall_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (v0w_r && q_active),
    .pt    (wall_rdata),
    .query (pt_r),
    .res   (dw)
  );

  opc_dist u_robot_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (v0r_r && q_active),
    .pt    (robot_rdata),
    .query (pt_r),
    .res   (dr)
  );

  assign wd_v = danger_of(dminw_r);
  assign rd_v = danger_of(dminr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= '0;
      rc_r        <= '0;
      thr_r       <= THR_RESET;
      v0w_r       <= 1'b0;
      v0r_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      v0w_r <= issue_w && !match_hit;
      v0r_r <= issue_r;
      a0_r  <= idx_r[WALL_AW-1:0];
      if (dw.valid && dw.sqd < DIST_W'(dminw_r)) begin
        dminw_r <= dw.sqd[DANGER_W-1:0];
      end
      if (dr.valid && dr.sqd < DIST_W'(dminr_r)) begin
        dminr_r <= dr.sqd[DANGER_W-1:0];
      end
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            pt_r      <= in_tdata;
            idx_r     <= '0;
            res_wd_r  <= '0;
            res_rd_r  <= '0;
            res_tot_r <= '0;
            res_blk_r <= 1'b0;
            res_st_r  <= STAT_OK;
            state_r   <= ST_DONE;
            unique case (cmd_in)
              CMD_ADD_WALL: begin
                if (wc_full) begin
                  res_st_r <= STAT_FULL;
                end else begin
                  wc_r <= wc_r + 1'b1;
                end
              end
              CMD_DEL_WALL:   state_r <= ST_RSRCH;
              CMD_CLR_WALLS:  wc_r <= '0;
              CMD_ADD_ROBOT: begin
                if (rc_full) begin
                  res_st_r <= STAT_FULL;
                end else begin
                  rc_r <= rc_r + 1'b1;
                end
              end
              CMD_CLR_ROBOTS: rc_r <= '0;
              CMD_QUERY: begin
                dminw_r <= DIST_START;
                dminr_r <= DIST_START;
                state_r <= ST_QSCAN;
              end
              default: ;
            endcase
          end
        end
        ST_QSCAN: begin
          if (w_more || r_more) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= ST_QDRAIN;
          end
        end
        ST_QDRAIN: begin
          if (!v0w_r && !v0r_r && !dw.valid && !dr.valid) begin
            state_r <= ST_QFIN;
          end
        end
        ST_QFIN: begin
          res_wd_r  <= wd_v;
          res_rd_r  <= rd_v;
          res_tot_r <= {1'b0, wd_v} + {1'b0, rd_v};
          res_blk_r <= ({1'b0, wd_v} > thr_r) || ({1'b0, rd_v} > thr_r);
          state_r   <= ST_DONE;
        end
        ST_RSRCH: begin
          priority if (match_hit) begin
            idx_r   <= SCAN_CW'(a0_r) + 1'b1;
            state_r <= ST_SHIFT;
          end else if (w_more) begin
            idx_r <= idx_r + 1'b1;
          end else if (!v0w_r) begin
            res_st_r <= STAT_NOMATCH;
            state_r  <= ST_DONE;
          end
        end
        ST_SHIFT: begin
          if (w_more) begin
            idx_r <= idx_r + 1'b1;
          end else if (!v0w_r) begin
            wc_r    <= wc_r - 1'b1;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_wd_r    <= res_wd_r;
            out_rd_r    <= res_rd_r;
            out_tot_r   <= res_tot_r;
            out_blk_r   <= res_blk_r;
            out_st_r    <= res_st_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_blk_r, out_tot_r, out_rd_r, out_wd_r};
  assign out_tuser  = out_st_r;

  `OPC_ASSERT(a_wall_cnt, clk, rst_n, wc_r <= WALL_CW'(MAX_WALLS), "wall count over table size")
  `OPC_ASSERT(a_robot_cnt, clk, rst_n, rc_r <= ROBOT_CW'(MAX_ROBOTS), "robot count over table size")
  `OPC_ASSERT(a_busy_after_take, clk, rst_n, in_fire |=> !in_tready, "item taken while busy")
  `OPC_ASSERT(a_dmin_bound, clk, rst_n, (dminw_r <= DIST_START) || !q_active, "wall minimum above start")
  `OPC_ASSERT(a_wall_write, clk, rst_n, wall_we |-> (state_r == ST_IDLE || state_r == ST_SHIFT), "wall table written during scan")
  `OPC_ASSERT_NORST(a_reset_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

// ===== tb/proximity_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the proximity cost block: tracks both point tables, predicts and compares.
module proximity_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [opc_pkg::POINT_W-1:0] in_tdata,   // pos_x, pos_y
  input  logic [opc_pkg::CMD_W-1:0]   in_tuser,   // command
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [opc_pkg::OUT_W-1:0]   out_tdata,  // wall_danger, robot_danger, total_danger, blocked
  input  logic [opc_pkg::STAT_W-1:0]  out_tuser,  // status
  input  logic                        cfg_wr_en,
  input  logic [opc_pkg::THR_W-1:0]   cfg_wr_data,
  output int                          fail_count,
  output int                          results_seen,
  output int                          pending,
  output int                          hit_count,
  output int                          drop_count,
  output int                          nomatch_count
);
  import opc_pkg::*;

  localparam longint unsigned FAR_DIST   = 10000;
  localparam longint unsigned NEAR_DIST  = 40;
  localparam longint unsigned COST_SCALE = 1000;
  localparam int unsigned     COST_HIT   = 10000;
  localparam logic [THR_W-1:0] THR_AFTER_RESET = 15'd400;

  localparam int ROBOT_LSB = DANGER_W;
  localparam int TOTAL_LSB = 2 * DANGER_W;
  localparam int BLK_BIT   = TOTAL_LSB + TOTAL_W;

  typedef struct packed {
    logic [DANGER_W-1:0] wall;
    logic [DANGER_W-1:0] robot;
    logic [TOTAL_W-1:0]  total;
    logic                blocked;
    logic [STAT_W-1:0]   status;
  } cost_t;

  cost_t              expected_costs[$];
  logic [POINT_W-1:0] wall_pts [MAX_WALLS];
  logic [POINT_W-1:0] robot_pts [MAX_ROBOTS];
  int                 wall_n;
  int                 robot_n;
  logic [THR_W-1:0]   threshold;

  function automatic longint unsigned sq_dist(logic [POINT_W-1:0] a, logic [POINT_W-1:0] b);
    longint ax, ay, bx, by;
    ax = $signed(a[COORD_W-1:0]);
    ay = $signed(a[POINT_W-1:COORD_W]);
    bx = $signed(b[COORD_W-1:0]);
    by = $signed(b[POINT_W-1:COORD_W]);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  function automatic logic [DANGER_W-1:0] cost_of(longint unsigned dmin);
    if (dmin == 0) return DANGER_W'(COST_HIT);
    if (dmin < NEAR_DIST) return DANGER_W'(COST_SCALE / dmin);
    return '0;
  endfunction

  // applies one command to the shadow tables and returns the result it should give
  function automatic cost_t apply_command(logic [CMD_W-1:0] cmd, logic [POINT_W-1:0] pt);
    cost_t             r;
    longint unsigned   wmin, rmin, d;
    int                i, hit;
    r = '0;
    wmin = FAR_DIST;
    rmin = FAR_DIST;
    hit = -1;
    case (cmd)
      CMD_ADD_WALL: begin
        if (wall_n < MAX_WALLS) begin
          wall_pts[wall_n] = pt;
          wall_n++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_DEL_WALL: begin
        r.status = STAT_NOMATCH;
        for (i = 0; i < wall_n; i++)
          if (hit < 0 && wall_pts[i] == pt) hit = i;
        if (hit >= 0) begin
          for (i = hit; i < wall_n - 1; i++) wall_pts[i] = wall_pts[i+1];
          wall_n--;
          r.status = STAT_OK;
        end
      end
      CMD_CLR_WALLS: wall_n = 0;
      CMD_ADD_ROBOT: begin
        if (robot_n < MAX_ROBOTS) begin
          robot_pts[robot_n] = pt;
          robot_n++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_CLR_ROBOTS: robot_n = 0;
      CMD_QUERY: begin
        for (i = 0; i < wall_n; i++) begin
          d = sq_dist(wall_pts[i], pt);
          if (d < wmin) wmin = d;
        end
        for (i = 0; i < robot_n; i++) begin
          d = sq_dist(robot_pts[i], pt);
          if (d < rmin) rmin = d;
        end
        r.wall    = cost_of(wmin);
        r.robot   = cost_of(rmin);
        r.total   = r.wall + r.robot;
        r.blocked = (r.wall > threshold) || (r.robot > threshold);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("t=%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    cost_t want;
    if (!rst_n) begin
      wall_n = 0;
      robot_n = 0;
      threshold = THR_AFTER_RESET;
      expected_costs.delete();
      fail_count = 0;
      results_seen = 0;
      hit_count = 0;
      drop_count = 0;
      nomatch_count = 0;
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_costs.size() == 0) begin
          fail_count++;
          $display("t=%0t unexpected result: expected none, got data %h status %0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_costs.pop_front();
          check_field("wall_danger", want.wall, out_tdata[ROBOT_LSB-1:0]);
          check_field("robot_danger", want.robot, out_tdata[TOTAL_LSB-1:ROBOT_LSB]);
          check_field("total_danger", want.total, out_tdata[BLK_BIT-1:TOTAL_LSB]);
          check_field("blocked", want.blocked, out_tdata[BLK_BIT]);
          check_field("tdata padding", 0, out_tdata[OUT_W-1:BLK_BIT+1]);
          check_field("status", want.status, out_tuser);
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_command(in_tuser, in_tdata);
        expected_costs.insert(expected_costs.size(), want);
        if (in_tuser == CMD_QUERY && (want.wall == COST_HIT || want.robot == COST_HIT))
          hit_count++;
        if (want.status == STAT_FULL) drop_count++;
        if (want.status == STAT_NOMATCH) nomatch_count++;
      end
    end
    pending = expected_costs.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the proximity cost block: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import opc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int STALL_MAX    = 11;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 166;
  localparam int N_PHASES     = 8;
  localparam int N_FIXED_THR  = 6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [POINT_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]    in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic [STAT_W-1:0]   out_tuser;
  logic                cfg_wr_en = 1'b0;
  logic [THR_W-1:0]    cfg_wr_data = '0;

  int fail_count, results_seen, pending, hit_count, drop_count, nomatch_count;
  int idle_cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  bit snd_quiet = 1'b0;
  bit rcv_quiet = 1'b0;
  logic [THR_W-1:0] thr_plan [N_FIXED_THR];

  always #5 clk = ~clk;

  obstacle_proximity_cost_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  proximity_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .results_seen  (results_seen),
    .pending       (pending),
    .hit_count     (hit_count),
    .drop_count    (drop_count),
    .nomatch_count (nomatch_count)
  );

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                      input logic [COORD_W-1:0] y);
    int gap;
    gap = snd_quiet ? 0 : $urandom_range(0, STALL_MAX);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] center);
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 16'hFFFF));
    return center + 16'($urandom_range(0, 12)) - 16'd6;
  endfunction

  // filling mode leans on adds so both tables overflow
  function automatic logic [CMD_W-1:0] pick_cmd(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 50) return CMD_ADD_WALL;
      if (r < 65) return CMD_ADD_ROBOT;
      if (r < 70) return CMD_DEL_WALL;
      if (r < 99) return CMD_QUERY;
    end else begin
      if (r < 22) return CMD_ADD_WALL;
      if (r < 34) return CMD_ADD_ROBOT;
      if (r < 48) return CMD_DEL_WALL;
      if (r < 88) return CMD_QUERY;
      if (r < 92) return CMD_CLR_WALLS;
      if (r < 96) return CMD_CLR_ROBOTS;
    end
    return r[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  // output side: fresh random stall before each transfer, none in quiet phases
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = rcv_quiet ? 0 : $urandom_range(0, STALL_MAX);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("t=%0t timeout: no transfer for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [COORD_W-1:0] center;
    logic [THR_W-1:0]   thr;
    bit                 filling;
    int                 ph, k;
    thr_plan = '{15'd0, 15'd20000, 15'd9999, 15'd10000, 15'd999, 15'd1000};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at the reset threshold
    send(CMD_QUERY,      16'd0,    16'd0);
    send(CMD_ADD_WALL,   16'h7FFF, 16'h8000);
    send(CMD_QUERY,      16'h8000, 16'h7FFF);
    send(CMD_ADD_WALL,   16'd0,    16'd0);
    send(CMD_QUERY,      16'd0,    16'd0);
    send(CMD_QUERY,      16'd1,    16'd0);
    send(CMD_QUERY,      16'd6,    16'd2);
    send(CMD_QUERY,      16'd6,    16'd1);
    send(CMD_ADD_ROBOT,  16'd3,    16'd3);
    send(CMD_QUERY,      16'd3,    16'd4);
    send(CMD_ADD_ROBOT,  16'hFFFF, 16'hFFFF);
    send(CMD_QUERY,      16'hFFFF, 16'hFFFF);
    send(CMD_DEL_WALL,   16'd5,    16'd5);
    send(CMD_DEL_WALL,   16'd0,    16'd0);
    send(CMD_QUERY,      16'd0,    16'd0);
    send(CMD_SPARE_LO,   16'd1,    16'd2);
    send(CMD_SPARE_HI,   16'hFFFF, 16'h8000);
    send(CMD_CLR_ROBOTS, 16'd0,    16'd0);
    send(CMD_QUERY,      16'd3,    16'd3);
    send(CMD_DEL_WALL,   16'h7FFF, 16'h8000);
    send(CMD_DEL_WALL,   16'h7FFF, 16'h8000);
    send(CMD_CLR_WALLS,  16'd0,    16'd0);
    send(CMD_QUERY,      16'h7FFF, 16'h7FFF);

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      thr = (ph < N_FIXED_THR) ? thr_plan[ph] : 15'($urandom_range(0, 20000));
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= thr;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      cfg_writes++;

      filling   = (ph % 4 == 0);
      snd_quiet = ($urandom_range(0, 3) == 0);
      rcv_quiet = ($urandom_range(0, 3) == 0);
      // mostly near the origin, some phases straddle the coordinate wrap
      if (ph == 3)      center = 16'h7FFC;
      else if (ph == 6) center = 16'h8003;
      else              center = 16'($urandom_range(0, 40)) - 16'd20;

      for (k = 0; k < PHASE_ITEMS; k++)
        send(pick_cmd(filling), pick_coord(center), pick_coord(center));
    end
    drain();

    $display("Sent %0d commands, checked %0d results across %0d threshold writes plus reset.",
             items_sent, results_seen, cfg_writes);
    $display("Direct-hit queries %0d, adds dropped on full table %0d, unmatched removes %0d.",
             hit_count, drop_count, nomatch_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
